// ----- rtl/weather_frame_bcd_decoder_assert.svh -----
// assertion macros for the weather frame decoder checker
// used by the checker file only, no other dependencies
`ifndef WEATHER_FRAME_BCD_DECODER_ASSERT_SVH
`define WEATHER_FRAME_BCD_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define WFBD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wfbd checker: property violated");

// next-cycle implication, disabled while reset is asserted
`define WFBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wfbd checker: property violated");

`endif

// ----- rtl/wfbd_pkg.sv -----
// shared types and constants for the weather frame decoder
// no dependencies
package wfbd_pkg;

    localparam int FrameLen = 26;
    localparam int HalfLen  = 13;
    localparam int CountW   = 5;
    localparam int TdataW   = 80;

    // whole frame, byte 0 in the lowest lane
    typedef logic [FrameLen-1:0][7:0] frame_t;

    // decoded result of one frame
    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  sensor_id;
        logic        battery_low;
        logic        temp_valid;
        logic [11:0] temp_tenths;
        logic        hum_valid;
        logic [6:0]  humidity_pct;
        logic [11:0] gust_tenths;
        logic [10:0] wind_avg_tenths;
        logic [3:0]  wind_dir_index;
        logic [14:0] rain_tenths;
    } result_t;

endpackage

// ----- rtl/weather_frame_bcd_decoder.sv -----
// top level of the weather frame decoder: stream ports and result register
// depends on wfbd_pkg, wfbd_capture and wfbd_decode
//
// One frame byte is taken per clock cycle while s_tready is high; a byte
// with s_tuser high starts a new frame and drops any unfinished one, and
// bytes outside a frame are dropped silently. The 26th byte sets a
// frame-complete flag; once the result register is free, the check and
// bcd decode, done in one pass over the stored frame, load the result
// register and m_tvalid rises. s_tready falls only while a complete frame
// waits for the result register, which holds an earlier result not yet taken;
// otherwise the block keeps taking one byte every cycle while a result waits.
module weather_frame_bcd_decoder
    import wfbd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte[7:0]
    input  logic              s_tuser,   // frame_start
    output logic              m_tvalid,
    input  logic              m_tready,
    // frame_ok[0], sensor_id[8:1], battery_low[9], temp_valid[10],
    // temp_tenths[22:11], hum_valid[23], humidity_pct[30:24],
    // gust_tenths[42:31], wind_avg_tenths[53:43], wind_dir_index[57:54],
    // rain_tenths[72:58], zero fill[79:73]
    output logic [TdataW-1:0] m_tdata
);

    frame_t  frame;
    logic    pending;
    logic    in_accept;
    logic    result_load;
    result_t res;
    result_t res_reg;
    logic    m_tvalid_reg, m_tvalid_next;

    // a finished frame moves on when the result register is free
    assign result_load = pending && (!m_tvalid_reg || m_tready);
    assign s_tready    = !pending || result_load;
    assign in_accept   = s_tvalid && s_tready;

    wfbd_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .result_load (result_load),
        .frame       (frame),
        .pending     (pending)
    );

    wfbd_decode u_decode (
        .frame (frame),
        .res   (res)
    );

    // output valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (result_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (result_load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0,
                       res_reg.rain_tenths,
                       res_reg.wind_dir_index,
                       res_reg.wind_avg_tenths,
                       res_reg.gust_tenths,
                       res_reg.humidity_pct,
                       res_reg.hum_valid,
                       res_reg.temp_tenths,
                       res_reg.temp_valid,
                       res_reg.battery_low,
                       res_reg.sensor_id,
                       res_reg.frame_ok};

endmodule

// ----- rtl/wfbd_capture.sv -----
// frame capture: byte counter, frame store and frame-complete flag
// depends on wfbd_pkg
module wfbd_capture
    import wfbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    input  logic       result_load,
    output frame_t     frame,
    output logic       pending
);

    logic [CountW-1:0] count_reg, count_next;
    logic [CountW-1:0] slot;
    logic              slot_open;
    logic              pending_reg, pending_next;
    frame_t            frame_reg;

    // a start byte always goes to position zero
    assign slot      = frame_start ? '0 : count_reg;
    assign slot_open = (slot < CountW'(FrameLen));

    // next count and frame-complete flag
    always_comb begin
        count_next   = count_reg;
        pending_next = pending_reg;
        if (result_load) begin
            pending_next = 1'b0;
        end
        if (in_accept && slot_open) begin
            count_next = slot + 1'b1;
            if (slot == CountW'(FrameLen - 1)) begin
                pending_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= CountW'(FrameLen);
            pending_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    // frame store, no reset needed
    always_ff @(posedge aclk) begin
        if (in_accept && slot_open) begin
            frame_reg[slot] <= data_byte;
        end
    end

    assign frame   = frame_reg;
    assign pending = pending_reg;

endmodule

// ----- rtl/wfbd_decode.sv -----
// integrity check and bcd field decode of one stored frame
// depends on wfbd_pkg
module wfbd_decode
    import wfbd_pkg::*;
(
    input  frame_t  frame,
    output result_t res
);

    logic        ok;
    logic [10:0] temp_mag;
    logic [11:0] temp_signed;
    logic        temp_ok;
    logic [7:0]  hum_sum;
    logic        hum_ok;
    logic [10:0] wavg_sum;
    logic [14:0] rain_sum;

    // every byte of the first half must be the complement of its partner
    always_comb begin
        ok = 1'b1;
        for (int i = 0; i < HalfLen; i++) begin
            if ((frame[i] ^ frame[i + HalfLen]) != 8'hff) begin
                ok = 1'b0;
            end
        end
    end

    // temperature, negative when the sign nibble is nonzero
    assign temp_mag = 11'(frame[20][3:0]) + 11'(frame[20][7:4]) * 11'd10
                    + 11'(frame[21][3:0]) * 11'd100;
    assign temp_signed = (frame[25][3:0] != 4'h0) ? (12'd0 - {1'b0, temp_mag})
                                                   : {1'b0, temp_mag};
    assign temp_ok = (frame[20][3:0] <= 4'd9);

    // humidity in percent
    assign hum_sum = 8'(frame[22][3:0]) + 8'(frame[22][7:4]) * 8'd10;
    assign hum_ok  = (frame[22][3:0] <= 4'd9) && (hum_sum <= 8'd100);

    // wind average and rain from bcd nibbles
    assign wavg_sum = 11'(frame[18][3:0]) + 11'(frame[18][7:4]) * 11'd10
                    + 11'(frame[19][3:0]) * 11'd100;
    assign rain_sum = 15'(frame[23][3:0]) + 15'(frame[23][7:4]) * 15'd10
                    + 15'(frame[24][3:0]) * 15'd100
                    + 15'(frame[24][7:4]) * 15'd1000;

    // result, all zero on a failed check
    always_comb begin
        res = '0;
        if (ok) begin
            res.frame_ok        = 1'b1;
            res.sensor_id       = frame[14];
            res.battery_low     = frame[25][7];
            res.temp_valid      = temp_ok;
            res.temp_tenths     = temp_ok ? temp_signed : 12'd0;
            res.hum_valid       = hum_ok;
            res.humidity_pct    = hum_ok ? hum_sum[6:0] : 7'd0;
            res.gust_tenths     = {frame[17][3:0], frame[16]};
            res.wind_avg_tenths = wavg_sum;
            res.wind_dir_index  = frame[17][7:4];
            res.rain_tenths     = rain_sum;
        end
    end

endmodule

// ----- rtl/wfbd_checker.sv -----
// port-level checker for the weather frame decoder, bound to the top level
// depends on wfbd_pkg and weather_frame_bcd_decoder_assert.svh
`include "weather_frame_bcd_decoder_assert.svh"

module wfbd_checker
    import wfbd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [7:0]        s_tdata,
    input logic              s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [TdataW-1:0] m_tdata
);

    // a stalled result holds still
    `WFBD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a failed check carries nothing but zeros
    `WFBD_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[79:1] == 79'd0)

    // invalid humidity reads zero, valid humidity stays at most one hundred
    `WFBD_ASSERT_IMPL(a_hum_range, aclk, aresetn, m_tvalid, m_tdata[23] ? (m_tdata[30:24] <= 7'd100) : (m_tdata[30:24] == 7'd0))

    // invalid temperature reads zero
    `WFBD_ASSERT_IMPL(a_temp_zero, aclk, aresetn, m_tvalid && !m_tdata[10], m_tdata[22:11] == 12'd0)

endmodule

bind weather_frame_bcd_decoder wfbd_checker u_wfbd_checker (.*);

// ----- verif/tb.sv -----
// self-checking bench for the weather frame decoder: byte stream in, decoded frame out
// depends on wfbd_pkg and weather_frame_bcd_decoder; needs no files or arguments
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wfbd_pkg::*;

    localparam int NumItems   = 1550;
    localparam int CycleLimit = 500000;
    localparam int SettleCyc  = 10;

    typedef logic [HalfLen-1:0][7:0] payload_t;

    // expected decoded frames, built from the accepted byte stream
    class frame_scoreboard;
        logic [7:0]  frame_bytes [FrameLen];
        int unsigned fill;
        result_t     expected_q [$];
        int          errors;

        function new();
            fill   = FrameLen;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // complement check plus bcd decode of the stored frame
        function result_t decode_frame();
            result_t     r;
            int unsigned lo [FrameLen];
            int unsigned hi [FrameLen];
            int unsigned sum;
            int unsigned tval;
            bit          ok;
            r  = '0;
            ok = 1'b1;
            for (int i = 0; i < FrameLen; i++) begin
                lo[i] = frame_bytes[i][3:0];
                hi[i] = frame_bytes[i][7:4];
            end
            for (int i = 0; i < HalfLen; i++)
                if ((frame_bytes[i] ^ frame_bytes[i+HalfLen]) != 8'hff)
                    ok = 1'b0;
            if (!ok)
                return r;
            r.frame_ok    = 1'b1;
            r.sensor_id   = frame_bytes[14];
            r.battery_low = frame_bytes[25][7];
            // temperature, negated when the sign nibble is nonzero
            sum  = lo[20] + 10 * hi[20] + 100 * lo[21];
            tval = (lo[25] != 0) ? 32'd0 - sum : sum;
            r.temp_valid = (lo[20] <= 9);
            if (r.temp_valid)
                r.temp_tenths = tval[11:0];
            // humidity, 100 is the top legal value
            sum = lo[22] + 10 * hi[22];
            r.hum_valid = (lo[22] <= 9) && (sum <= 100);
            if (r.hum_valid)
                r.humidity_pct = sum[6:0];
            r.gust_tenths    = {frame_bytes[17][3:0], frame_bytes[16]};
            r.wind_dir_index = frame_bytes[17][7:4];
            sum = lo[18] + 10 * hi[18] + 100 * lo[19];
            r.wind_avg_tenths = sum[10:0];
            sum = lo[23] + 10 * hi[23] + 100 * lo[24] + 1000 * hi[24];
            r.rain_tenths = sum[14:0];
            return r;
        endfunction

        // accepted input transaction
        function void note_byte(logic [7:0] d, logic st);
            if (st)
                fill = 0;
            if (fill >= FrameLen)
                return;
            frame_bytes[fill] = d;
            fill++;
            if (fill == FrameLen)
                expected_q.push_back(decode_frame());
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            $display("tb: %s mismatch, got 0x%0h expected 0x%0h", what, got, want);
            errors++;
        endtask

        // accepted result transaction against the oldest expectation
        task check_result(logic [TdataW-1:0] td);
            result_t want;
            if (expected_q.size() == 0) begin
                report("unexpected result", td[15:0], 16'd0);
                return;
            end
            want = expected_q.pop_front();
            if (td[0] !== want.frame_ok)
                report("frame_ok", td[0], want.frame_ok);
            if (td[8:1] !== want.sensor_id)
                report("sensor_id", td[8:1], want.sensor_id);
            if (td[9] !== want.battery_low)
                report("battery_low", td[9], want.battery_low);
            if (td[10] !== want.temp_valid)
                report("temp_valid", td[10], want.temp_valid);
            if (td[22:11] !== want.temp_tenths)
                report("temp_tenths", td[22:11], want.temp_tenths);
            if (td[23] !== want.hum_valid)
                report("hum_valid", td[23], want.hum_valid);
            if (td[30:24] !== want.humidity_pct)
                report("humidity_pct", td[30:24], want.humidity_pct);
            if (td[42:31] !== want.gust_tenths)
                report("gust_tenths", td[42:31], want.gust_tenths);
            if (td[53:43] !== want.wind_avg_tenths)
                report("wind_avg_tenths", td[53:43], want.wind_avg_tenths);
            if (td[57:54] !== want.wind_dir_index)
                report("wind_dir_index", td[57:54], want.wind_dir_index);
            if (td[72:58] !== want.rain_tenths)
                report("rain_tenths", td[72:58], want.rain_tenths);
        endtask
    endclass

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;   // data_byte[7:0]
    logic              s_tuser  = 1'b0;    // frame_start
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [TdataW-1:0] m_tdata;            // decoded fields, see dut port list

    frame_scoreboard sb = new();
    int              items_sent = 0;
    int              burst_left = 0;
    int              cycle_count;
    int              rx_mode = 0;
    int              rx_mode_left = 0;
    int unsigned     rx_phase = 0;
    logic [15:0]     stall_pat = 16'b1100_1110_0001_1011;

    weather_frame_bcd_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // result side: check accepted transactions, stall in changing modes
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 400);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: begin
                m_tready <= stall_pat[rx_phase % 16];
                rx_phase++;
            end
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // one input transaction, with bursts and random gaps
    task send_byte(input logic [7:0] d, input logic st);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_byte(d, st);
        burst_left--;
    endtask

    // first nbytes of a frame, start flag on byte 0
    task send_frame(input frame_t fr, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(fr[i], i == 0);
        items_sent += nbytes;
    endtask

    // hold the sender until every expected result is out
    task drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // payload goes to bytes 13..25, its complement to bytes 0..12
    function frame_t seal(payload_t pl);
        frame_t f;
        for (int i = 0; i < HalfLen; i++) begin
            f[i+HalfLen] = pl[i];
            f[i]         = ~pl[i];
        end
        return f;
    endfunction

    function logic [7:0] bcd_or_raw();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    // mostly plausible readings, some raw nibbles, some broken checks
    function frame_t random_frame();
        payload_t    pl;
        frame_t      f;
        int unsigned hum;
        for (int i = 0; i < HalfLen; i++)
            pl[i] = 8'($urandom);
        pl[5]  = bcd_or_raw();
        pl[6]  = bcd_or_raw();
        pl[7]  = bcd_or_raw();
        pl[8]  = bcd_or_raw();
        pl[10] = bcd_or_raw();
        pl[11] = bcd_or_raw();
        hum    = $urandom_range(0, 100);
        pl[9]  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : {4'(hum / 10), 4'(hum % 10)};
        if ($urandom_range(0, 1) == 0)
            pl[12][3:0] = 4'h0;
        f = seal(pl);
        if ($urandom_range(0, 4) == 0)
            f[$urandom_range(0, FrameLen-1)][$urandom_range(0, 7)] ^= 1'b1;
        return f;
    endfunction

    initial begin
        payload_t pl;
        frame_t   f;
        int       kind;
        int       n;
        bit       drained;
        drained = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero and all-ones payloads
        pl = '0;
        send_frame(seal(pl), FrameLen);
        pl = '1;
        send_frame(seal(pl), FrameLen);
        // negative temperature, humidity exactly 100, top bcd values
        pl = '0;
        pl[1]  = 8'h5a;
        pl[3]  = 8'hff;
        pl[4]  = 8'hf0;
        pl[5]  = 8'h99;
        pl[6]  = 8'h09;
        pl[7]  = 8'h09;
        pl[8]  = 8'h0f;
        pl[9]  = 8'ha0;
        pl[10] = 8'h99;
        pl[11] = 8'h99;
        pl[12] = 8'h81;
        send_frame(seal(pl), FrameLen);
        // invalid temperature digit, humidity 101
        pl[7]  = 8'h0a;
        pl[9]  = 8'ha1;
        pl[12] = 8'h70;
        send_frame(seal(pl), FrameLen);
        // failed complement check
        f = random_frame();
        f[0][0] = ~f[0][0];
        send_frame(f, FrameLen);
        // restart inside an open frame
        send_frame(random_frame(), 10);
        send_frame(random_frame(), FrameLen);
        // bytes with no frame open are dropped
        repeat (3) send_byte(8'($urandom), 1'b0);
        items_sent += 3;
        drain();

        // random traffic: mostly whole frames, some cut short, some noise
        while (items_sent < NumItems) begin
            if (!drained && items_sent > NumItems / 2) begin
                drain();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                send_frame(random_frame(), FrameLen);
            end else if (kind < 84) begin
                send_frame(random_frame(), $urandom_range(1, FrameLen-1));
            end else if (kind < 92) begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom), 1'b0);
                items_sent += n;
            end else begin
                n = $urandom_range(1, 30);
                repeat (n) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                items_sent += n;
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SettleCyc) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
